// ----- src/mfw_pkg.sv -----
package mfw_pkg;

	localparam logic [3:0] FMT_F32  = 4'd0;
	localparam logic [3:0] FMT_F64  = 4'd1;
	localparam logic [3:0] FMT_F16  = 4'd2;
	localparam logic [3:0] FMT_BF16 = 4'd3;
	localparam logic [3:0] FMT_E4M3 = 4'd4;
	localparam logic [3:0] FMT_E5M2 = 4'd5;
	localparam logic [3:0] FMT_I8   = 4'd6;
	localparam logic [3:0] FMT_U8   = 4'd7;
	localparam logic [3:0] FMT_I16  = 4'd8;
	localparam logic [3:0] FMT_I32  = 4'd9;
	localparam logic [3:0] FMT_I64  = 4'd10;

	// first and last code with no source format behind it
	localparam logic [3:0] FMT_UNSUP_LO = 4'd11;
	localparam logic [3:0] FMT_UNSUP_HI = 4'd15;

	localparam logic [31:0] F32_QNAN = 32'h7FC0_0000;
	localparam logic [31:0] F32_INF  = 32'h7F80_0000;

	// result class from decode to pack
	localparam logic [1:0] CLS_DIRECT = 2'd0;
	localparam logic [1:0] CLS_NORM   = 2'd1;

	// decoded item: either a final word or a significand to normalize and round
	typedef struct packed {
		logic        sign;
		logic [1:0]  cls;
		logic [31:0] direct;
		logic [63:0] mag;      // value = mag * 2^(bexp - 63 - 1023), cls norm
		logic [11:0] bexp;     // biased by 1023, as f64
		logic        bad;
	} mfw_dec_t;

	// normalized item: mag has its top bit set, cls norm
	typedef struct packed {
		logic        sign;
		logic [1:0]  cls;
		logic [31:0] direct;
		logic [63:0] mag;
		logic signed [13:0] exp32;  // binary32 biased exponent of the top bit
		logic        bad;
	} mfw_nrm_t;

endpackage

// ----- src/multi_format_to_fp32_widener_unit.sv -----
// throughput: one request per cycle while the output is not stalled; stages are decode, normalize, round, output
// a stall holds every stage that holds a request; empty stages still fill
// arst_n clears all valid bits and source_format to f32
module multi_format_to_fp32_widener_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] element_bits,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] float_bits,
	output logic        unsupported
);

	logic [3:0] source_format_q;
	mfw_pkg::mfw_dec_t dec, dec_s1;
	mfw_pkg::mfw_nrm_t nrm, nrm_s2;
	logic [31:0] res, res_s3;
	logic bad, bad_s3;
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3, adv4;

	// format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) source_format_q <= mfw_pkg::FMT_F32;
		else if (cfg_we) source_format_q <= cfg_wdata;
	end

	mfw_decode u_dec (.fmt(source_format_q), .x(element_bits), .dec(dec));
	mfw_norm   u_nrm (.dec(dec_s1), .nrm(nrm));
	mfw_round  u_rnd (.nrm(nrm_s2), .res(res), .bad(bad));

	// stall chain: a stage moves when the one after it can take it
	assign adv4 = !out_stall || !out_valid;
	assign adv3 = adv4 || !v_s3;
	assign adv2 = adv3 || !v_s2;
	assign adv1 = adv2 || !v_s1;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) out_valid <= v_s3;
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (adv1) dec_s1 <= dec;
		if (adv2) nrm_s2 <= nrm;
		if (adv3) begin
			res_s3 <= res;
			bad_s3 <= bad;
		end
		if (adv4) begin
			float_bits <= res_s3;
			unsupported <= bad_s3;
		end
	end

endmodule

// ----- src/mfw_decode.sv -----
module mfw_decode (
	input  logic [3:0]       fmt,
	input  logic [63:0]      x,
	output mfw_pkg::mfw_dec_t dec
);

	logic [7:0]  e5h;
	logic [15:0] h;
	logic        hs;
	logic [4:0]  he;
	logic [9:0]  hm;
	logic [64:0] neg64;

	always_comb begin
		dec = '0;
		e5h = x[7:0];
		h = (fmt == mfw_pkg::FMT_E5M2) ? {e5h, 8'h00} : x[15:0];
		hs = h[15];
		he = h[14:10];
		hm = h[9:0];
		neg64 = 65'd0;
		unique case (fmt) inside
		mfw_pkg::FMT_F32: begin
			dec.direct = x[31:0];
		end
		mfw_pkg::FMT_BF16: begin
			dec.direct = {x[15:0], 16'h0000};
		end
		mfw_pkg::FMT_F64: begin
			dec.sign = x[63];
			if (x[62:52] == 11'h7FF) begin
				if (x[51:0] == 52'd0) dec.direct = {x[63], 31'h7F80_0000};
				else dec.direct = {x[63], 31'h7FC0_0000} | {9'd0, x[51:29]};
			end else if (x[62:52] == 11'd0) begin
				dec.direct = {x[63], 31'd0};
			end else begin
				// value = sig * 2^(e-1075), sig moved up by 11
				dec.cls = mfw_pkg::CLS_NORM;
				dec.mag = {1'b1, x[51:0], 11'd0};
				dec.bexp = {1'b0, x[62:52]};
			end
		end
		mfw_pkg::FMT_F16, mfw_pkg::FMT_E5M2: begin
			dec.sign = hs;
			if (he == 5'h1F) begin
				if (hm == 10'd0) dec.direct = {hs, 31'h7F80_0000};
				else dec.direct = {hs, 31'h7FC0_0000} | {9'd0, hm, 13'd0};
			end else if (he == 5'd0 && hm == 10'd0) begin
				dec.direct = {hs, 31'd0};
			end else begin
				// value = m * 2^(e-25), subnormal e=1 without hidden bit
				dec.cls = mfw_pkg::CLS_NORM;
				dec.mag = {53'd0, (he != 5'd0), hm};
				dec.bexp = 12'd1023 + 12'd63 - 12'd25 + {7'd0, (he == 5'd0) ? 5'd1 : he};
			end
		end
		mfw_pkg::FMT_E4M3: begin
			dec.sign = x[7];
			if (x[6:0] == 7'h7F) begin
				dec.direct = {x[7], 31'h7FC0_0000};
			end else if (x[6:0] == 7'd0) begin
				dec.direct = {x[7], 31'd0};
			end else begin
				// value = m * 2^(e-10)
				dec.cls = mfw_pkg::CLS_NORM;
				dec.mag = {60'd0, (x[6:3] != 4'd0), x[2:0]};
				dec.bexp = 12'd1023 + 12'd63 - 12'd10
					+ {8'd0, (x[6:3] == 4'd0) ? 4'd1 : x[6:3]};
			end
		end
		mfw_pkg::FMT_I8, mfw_pkg::FMT_U8, mfw_pkg::FMT_I16,
		mfw_pkg::FMT_I32, mfw_pkg::FMT_I64: begin
			unique case (fmt)
			mfw_pkg::FMT_I8:  neg64 = {{57{x[7]}}, x[7:0]};
			mfw_pkg::FMT_U8:  neg64 = {57'd0, x[7:0]};
			mfw_pkg::FMT_I16: neg64 = {{49{x[15]}}, x[15:0]};
			mfw_pkg::FMT_I32: neg64 = {{33{x[31]}}, x[31:0]};
			default:          neg64 = {x[63], x};
			endcase
			dec.sign = neg64[64];
			dec.mag = neg64[64] ? (64'd0 - neg64[63:0]) : neg64[63:0];
			if (dec.mag == 64'd0) dec.direct = {neg64[64], 31'd0};
			else dec.cls = mfw_pkg::CLS_NORM;
			dec.bexp = 12'd1023 + 12'd63;
		end
		default: begin
			dec.bad = 1'b1;
		end
		endcase
	end

endmodule

// ----- src/mfw_norm.sv -----
module mfw_norm (
	input  mfw_pkg::mfw_dec_t dec,
	output mfw_pkg::mfw_nrm_t nrm
);

	logic [5:0]  lz;
	logic        found;

	// leading-zero count by priority scan
	always_comb begin
		lz = 6'd0;
		found = 1'b0;
		for (int i = 63; i >= 0; i--) begin
			if (!found && dec.mag[i]) begin
				lz = 6'(63 - i);
				found = 1'b1;
			end
		end
		nrm.sign = dec.sign;
		nrm.cls = dec.cls;
		nrm.direct = dec.direct;
		nrm.bad = dec.bad;
		nrm.mag = dec.mag << lz;
		nrm.exp32 = $signed({2'b00, dec.bexp}) - 14'sd896 - $signed({8'd0, lz});
	end

endmodule

// ----- src/mfw_round.sv -----
module mfw_round (
	input  mfw_pkg::mfw_nrm_t nrm,
	output logic [31:0]       res,
	output logic              bad
);

	logic [6:0]  sh;
	logic [63:0] keep;
	logic [63:0] rem;
	logic [63:0] half;
	logic [63:0] rnd;
	logic [31:0] mag;
	logic signed [13:0] te;

	// round the normalized value to binary32, ties to even
	always_comb begin
		te = nrm.exp32;
		// shift for normal = 40; subnormal adds 1-te; below half the smallest gives zero
		if (te >= 14'sd1) sh = 7'd40;
		else if (te < -14'sd23) sh = 7'd65;
		else sh = 7'(14'sd41 - te);
		if (sh >= 7'd64) begin
			keep = 64'd0;
			rem = nrm.mag;
			half = 64'h8000_0000_0000_0000;
			rnd = (sh == 7'd64 && nrm.mag > half) ? 64'd1 : 64'd0;
		end else begin
			keep = nrm.mag >> sh[5:0];
			rem = nrm.mag & ((64'd1 << sh[5:0]) - 64'd1);
			half = 64'd1 << (sh[5:0] - 6'd1);
			rnd = keep + ((rem > half || (rem == half && keep[0])) ? 64'd1 : 64'd0);
		end
		if (te >= 14'sd1) mag = {te[8:0] - 9'd1, 23'd0} + rnd[31:0];
		else mag = rnd[31:0];
		if (te >= 14'sd255 || mag[30:23] == 8'hFF) mag = mfw_pkg::F32_INF;
		bad = nrm.bad;
		if (nrm.bad) res = 32'd0;
		else if (nrm.cls == mfw_pkg::CLS_DIRECT) res = nrm.direct;
		else res = {nrm.sign, mag[30:0]};
	end

endmodule

// ----- src/mfw_checker.sv -----
module mfw_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] float_bits,
	input logic        unsupported
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(float_bits))
		else $error("stalled result changed");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unsupported |-> float_bits == 32'd0)
		else $error("unsupported result not zero");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid && !out_valid ##1 !in_valid |-> !in_stall)
		else $error("stall without work");

endmodule

bind multi_format_to_fp32_widener_unit mfw_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall),
	.float_bits(float_bits), .unsupported(unsupported)
);
